FILE: design/foct_pkg.sv
// Package for the fan on/off cycle tester.
// Holds port widths, register indexes, phase codes, the sequencer state type
// and the divider interface types. No dependencies.
package foct_pkg;

  // Stream and configuration port widths
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // Shared divider operand widths
  localparam int unsigned DivDividendW = 48;
  localparam int unsigned DivDivisorW  = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ON_SECONDS     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_SECONDS    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CYCLE_TOTAL    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TEST_FREQ_HZ   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PULSES_PER_REV = 3'd4;

  // Register reset values
  localparam logic [11:0] OnSecondsRst    = 12'd10;
  localparam logic [11:0] OffSecondsRst   = 12'd10;
  localparam logic [7:0]  CycleTotalRst   = 8'd1;
  localparam logic [19:0] TestFreqHzRst   = 20'd25000;
  localparam logic [7:0]  PulsesPerRevRst = 8'd2;

  // Phase codes
  localparam logic [1:0] PHASE_OFF  = 2'd0;
  localparam logic [1:0] PHASE_ON   = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;

  // Arithmetic constants
  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned RpmPerHz   = 60;
  localparam int unsigned Percent    = 100;
  localparam int unsigned ErrPctLim  = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_TGT_GO,
    ST_TGT_WAIT,
    ST_CHECK
  } seq_state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/foct_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the tester.
// Depends on foct_pkg for operand widths and the control/status structs.
module foct_divider import foct_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_ctrl_t               ctrl_i,
  input  logic [DivDividendW-1:0] dividend_i,
  input  logic [DivDivisorW-1:0]  divisor_i,
  output div_stat_t               stat_o,
  output logic [DivDividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DivDividendW);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [DivDivisorW-1:0]  rem_q, rem_d;
  logic [DivDividendW-1:0] quo_q, quo_d;
  logic [DivDivisorW-1:0]  dsr_q, dsr_d;

  logic [DivDivisorW:0]    rem_sh;
  logic                    fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DivDividendW-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when the divisor fits
      rem_d = fits ? DivDivisorW'(rem_sh - {1'b0, dsr_q}) : rem_sh[DivDivisorW-1:0];
      quo_d = {quo_q[DivDividendW-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivDividendW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

FILE: design/fan_on_off_cycle_tester.sv
// Top level of the fan on/off cycle tester: pass sequencing, record build.
// Depends on foct_pkg and foct_divider.
//
// Channel  | Direction | Handshake              | Content
// ---------+-----------+------------------------+------------------------------
// s_axis   | in        | tvalid/tready          | one sampling pass
// m_axis   | out       | tvalid/tready          | one result per pass
// cfg      | in        | cfg_valid_i/cfg_ready_o| register index and write data
//
// A pass that does not close an ON period is accepted in the idle state and its
// result sits in the output register on the next cycle.
// A pass that closes an ON period runs the shared 48-step restoring divider
// twice (average, then target RPM), then goes through the check state.
// Input is taken only in the idle state while the output register is free or
// being drained, so a stalled result holds the input off after one pass.
// Reset restores the register defaults and the test state; no clearing pass.
module fan_on_off_cycle_tester import foct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] time_ms, [32] run_request, [48:33] rpm_sample, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] pwm_on, [2:1] phase_now, [3] record_valid, [11:4] record_cycle,
  // [27:12] record_target, [43:28] record_max, [59:44] record_avg,
  // [60] record_error, [61] spin-up seen, [62] test_done, [63] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef struct packed {
    logic        pad;
    logic        test_done;
    logic        spun_up;
    logic        error;
    logic [15:0] avg;
    logic [15:0] max;
    logic [15:0] target;
    logic [7:0]  cycle;
    logic        rec_valid;
    logic [1:0]  phase_now;
    logic        pwm_on;
  } out_item_t;

  // Configuration registers
  logic [11:0] on_sec_q, off_sec_q;
  logic [7:0]  cyc_total_q, ppr_q;
  logic [19:0] freq_q;

  // Test state
  logic [1:0]  phase_q;
  logic [7:0]  cycles_q;
  logic [31:0] start_ms_q;
  logic [15:0] peak_q;
  logic [47:0] total_q;
  logic [31:0] count_q;
  logic        run_seen_q;

  // Pending record (held while the divider works)
  logic [1:0]  res_phase_q;
  logic        res_done_q;
  logic [7:0]  res_cycle_q;
  logic [15:0] res_max_q;
  logic [15:0] avg_q;
  logic [15:0] target_q;

  // Output register
  logic        out_valid_q;
  out_item_t   out_q;
  out_item_t   pass_item;
  out_item_t   rec_item;

  seq_state_e  state_q, state_d;

  // Pass update, evaluated on the incoming item
  logic [31:0] in_time;
  logic        in_run;
  logic [15:0] in_rpm;
  logic [1:0]  p_phase;
  logic [7:0]  p_cycles;
  logic [31:0] p_start;
  logic [15:0] p_peak;
  logic [47:0] p_total;
  logic [31:0] p_count;
  logic        p_rec;
  logic        p_done;
  logic [31:0] on_limit, off_limit;

  // Sequencer controls
  logic        accept;
  logic        out_free;
  logic        load_pass, load_rec;
  logic        cap_avg, cap_tgt;

  // Divider
  div_ctrl_t               div_ctrl;
  div_stat_t               div_stat;
  logic [DivDividendW-1:0] div_dividend;
  logic [DivDivisorW-1:0]  div_divisor;
  logic [DivDividendW-1:0] div_quo;
  logic [25:0]             freq_x60;

  // Error check
  logic [15:0] diff;
  logic        rec_err;

  assign in_time = s_axis_tdata[31:0];
  assign in_run  = s_axis_tdata[32];
  assign in_rpm  = s_axis_tdata[48:33];

  assign on_limit  = 32'(on_sec_q) * 32'(MsPerSec);
  assign off_limit = 32'(off_sec_q) * 32'(MsPerSec);

  // Configuration writes; always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_sec_q    <= OnSecondsRst;
      off_sec_q   <= OffSecondsRst;
      cyc_total_q <= CycleTotalRst;
      freq_q      <= TestFreqHzRst;
      ppr_q       <= PulsesPerRevRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ON_SECONDS:     on_sec_q    <= cfg_data_i[11:0];
        CFG_OFF_SECONDS:    off_sec_q   <= cfg_data_i[11:0];
        CFG_CYCLE_TOTAL:    cyc_total_q <= cfg_data_i[7:0];
        CFG_TEST_FREQ_HZ:   freq_q      <= cfg_data_i;
        CFG_PULSES_PER_REV: ppr_q       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // One sampling pass: run edge, ON sampling, phase timing
  always_comb begin
    logic [31:0] elapsed;
    p_phase  = phase_q;
    p_cycles = cycles_q;
    p_start  = start_ms_q;
    p_peak   = peak_q;
    p_total  = total_q;
    p_count  = count_q;
    p_rec    = 1'b0;
    p_done   = 1'b0;
    // a rising run request restarts the test with a fresh ON phase
    if (in_run && !run_seen_q) begin
      p_cycles = '0;
      p_phase  = PHASE_ON;
      p_start  = in_time;
      p_peak   = '0;
      p_total  = '0;
      p_count  = '0;
    end
    elapsed = in_time - p_start;
    if (!in_run) begin
      p_phase = PHASE_OFF;
    end else if (p_phase != PHASE_DONE) begin
      if (p_phase == PHASE_ON) begin
        if (in_rpm > p_peak) begin
          p_peak = in_rpm;
        end
        // freeze sum and count once the count saturates
        if (p_count != '1) begin
          p_total = p_total + 48'(in_rpm);
          p_count = p_count + 32'd1;
        end
        if (elapsed >= on_limit) begin
          p_rec    = 1'b1;
          p_cycles = p_cycles + 8'd1;
          p_phase  = PHASE_OFF;
          p_start  = in_time;
        end
      end else if (elapsed >= off_limit) begin
        if (p_cycles >= cyc_total_q) begin
          p_phase = PHASE_DONE;
          p_done  = 1'b1;
        end else begin
          p_phase = PHASE_ON;
          p_start = in_time;
          p_peak  = '0;
          p_total = '0;
          p_count = '0;
        end
      end
    end
  end

  // Result of a pass that closes no ON period
  always_comb begin
    pass_item           = '0;
    pass_item.pwm_on    = p_phase == PHASE_ON;
    pass_item.phase_now = p_phase;
    pass_item.test_done = p_done;
  end

  // Deviation check: floor(diff*100/target) > 20 is diff*100 >= 21*target
  always_comb begin
    diff    = (avg_q >= target_q) ? (avg_q - target_q) : (target_q - avg_q);
    rec_err = (avg_q == '0) ||
              ((target_q != '0) &&
               (23'(diff) * 23'(Percent) >= 23'(target_q) * 23'(ErrPctLim + 1)));
  end

  always_comb begin
    rec_item            = '0;
    rec_item.pwm_on     = res_phase_q == PHASE_ON;
    rec_item.phase_now  = res_phase_q;
    rec_item.rec_valid  = 1'b1;
    rec_item.cycle      = res_cycle_q;
    rec_item.target     = target_q;
    rec_item.max        = res_max_q;
    rec_item.avg        = avg_q;
    rec_item.error      = rec_err;
    rec_item.spun_up    = res_max_q != '0;
    rec_item.test_done  = res_done_q;
  end

  // Sequencer: next state and controls
  assign out_free = !out_valid_q || m_axis_tready;
  assign freq_x60 = 26'(freq_q) * 26'(RpmPerHz);

  always_comb begin
    state_d        = state_q;
    s_axis_tready  = 1'b0;
    accept         = 1'b0;
    load_pass      = 1'b0;
    load_rec       = 1'b0;
    cap_avg        = 1'b0;
    cap_tgt        = 1'b0;
    div_ctrl.start = 1'b0;
    div_dividend   = total_q;
    div_divisor    = count_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        accept        = s_axis_tvalid && out_free;
        if (accept) begin
          if (p_rec) begin
            state_d = ST_AVG_GO;
          end else begin
            load_pass = 1'b1;
          end
        end
      end
      ST_AVG_GO: begin
        div_ctrl.start = 1'b1;
        state_d        = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_stat.done) begin
          cap_avg = 1'b1;
          state_d = ST_TGT_GO;
        end
      end
      ST_TGT_GO: begin
        div_ctrl.start = 1'b1;
        div_dividend   = DivDividendW'(freq_x60);
        div_divisor    = DivDivisorW'(ppr_q);
        state_d        = ST_TGT_WAIT;
      end
      ST_TGT_WAIT: begin
        div_dividend = DivDividendW'(freq_x60);
        div_divisor  = DivDivisorW'(ppr_q);
        if (div_stat.done) begin
          cap_tgt = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // hold the record until the output register can take it
        if (out_free) begin
          load_rec = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Test state advances on every accepted pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PHASE_OFF;
      cycles_q   <= '0;
      start_ms_q <= '0;
      peak_q     <= '0;
      total_q    <= '0;
      count_q    <= '0;
      run_seen_q <= 1'b0;
    end else if (accept) begin
      phase_q    <= p_phase;
      cycles_q   <= p_cycles;
      start_ms_q <= p_start;
      peak_q     <= p_peak;
      total_q    <= p_total;
      count_q    <= p_count;
      run_seen_q <= in_run;
    end
  end

  // Pending record fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_phase_q <= p_phase;
      res_done_q  <= p_done;
      res_cycle_q <= p_cycles;
      res_max_q   <= p_peak;
    end
    if (cap_avg) begin
      avg_q <= (count_q == '0) ? 16'd0 : div_quo[15:0];
    end
    if (cap_tgt) begin
      target_q <= (ppr_q == '0) ? 16'd0 : div_quo[15:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_pass || load_rec) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pass) begin
      out_q <= pass_item;
    end else if (load_rec) begin
      out_q <= rec_item;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  foct_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // Input is taken only by the idle sequencer
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  // Divider completes only while the sequencer waits on it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_AVG_WAIT || state_q == ST_TGT_WAIT))
    else $error("divider done in unexpected state");

  // Never restart the divider in the middle of a division
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // PWM flag of a result agrees with its phase
  a_pwm_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.pwm_on == (out_q.phase_now == PHASE_ON)))
    else $error("pwm_on disagrees with phase_now");

  // A record leaving the check state shows up at the output
  a_check_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && out_free) |=> m_axis_tvalid)
    else $error("record lost after check");

endmodule
